FILE: design/nst_pkg.sv
package nst_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int NAME_W        = 32;
    localparam int COUNT_W       = 32;
    localparam int HANDLE_W      = 7;

    typedef enum logic [1:0]
    {
        FUNC_OPEN  = 2'd0,
        FUNC_CLOSE = 2'd1,
        FUNC_UP    = 2'd2,
        FUNC_DOWN  = 2'd3
    } func_t;

    typedef enum logic [1:0]
    {
        ST_OK   = 2'd0,
        ST_FAIL = 2'd1,
        ST_WAIT = 2'd2
    } status_t;

    // request held while the cells work on it
    typedef struct packed
    {
        func_t                      func;
        logic signed [NAME_W-1:0]   sem_name;
        logic signed [COUNT_W-1:0]  init_value;
    } req_t;

    // control broadcast from the top level to every cell
    typedef struct packed
    {
        logic fire;
        logic open_ok;
    } cell_ctl_t;

    // summary passed from one cell to the next
    typedef struct packed
    {
        logic                free_seen;
        logic                hit;
        logic                zero;
        logic [HANDLE_W-1:0] handle;
    } cell_link_t;

endpackage

FILE: design/nst_req_if.sv
interface nst_req_if;
    import nst_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 func;
    logic signed [NAME_W-1:0]   sem_name;
    logic signed [COUNT_W-1:0]  init_value;

    modport source
    (
        output valid,
        output func,
        output sem_name,
        output init_value,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  func,
        input  sem_name,
        input  init_value,
        output ready
    );
endinterface

FILE: design/nst_rsp_if.sv
interface nst_rsp_if;
    import nst_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] handle;
    logic                wake_waiters;

    modport source
    (
        output valid,
        output status,
        output handle,
        output wake_waiters,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  status,
        input  handle,
        input  wake_waiters,
        output ready
    );
endinterface

FILE: design/named_semaphore_table.sv
// flow: an accepted request waits in the request register, which holds one item
//   while the cell row resolves it; its result is registered and offered as a result
//   beat once the result register can take it; then the next request beat is taken
// reset: rst_n clears every entry's valid flag and the handshake state at once;
//   entry names and counts are not reset and are only read behind a valid flag
module named_semaphore_table
(
    input  logic      clk,
    input  logic      rst_n,
    nst_req_if.sink   req,
    nst_rsp_if.source rsp
);
    import nst_pkg::*;

    // request register and its occupancy flag
    req_t        req_reg;
    logic        busy_reg;
    logic        busy_next;

    // result register toward the response channel
    logic        out_valid_reg;
    logic        out_valid_next;
    status_t     status_reg;
    status_t     status_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    logic        wake_reg;
    logic        wake_next;

    logic        accept;
    logic        fire;
    cell_ctl_t   ctl;
    cell_link_t  link [TABLE_ENTRIES+1];
    cell_link_t  summary;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    // resolve the held request once the result register can take it
    assign fire      = busy_reg && (!out_valid_reg || rsp.ready);

    assign link[0] = '0;
    assign summary = link[TABLE_ENTRIES];

    // an open commits only for a new name with a free entry somewhere
    assign ctl.fire    = fire;
    assign ctl.open_ok = !summary.hit && summary.free_seen;

    // row of entry cells; the lowest free entry is the first one whose
    // incoming summary has seen no free entry yet
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        nst_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (req_reg),
            .ctl      (ctl),
            .slot     (HANDLE_W'(i + 1)),
            .link_in  (link[i]),
            .link_out (link[i+1])
        );
    end

    // response decode from the row summary
    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        handle_next    = handle_reg;
        wake_next      = wake_reg;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        if (accept)
            busy_next = 1'b1;

        if (fire)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            status_next    = ST_FAIL;
            handle_next    = '0;
            wake_next      = 1'b0;
            case (req_reg.func)
                FUNC_OPEN:
                begin
                    if (ctl.open_ok)
                    begin
                        status_next = ST_OK;
                        handle_next = summary.handle;
                    end
                end
                FUNC_CLOSE:
                begin
                    if (summary.hit)
                        status_next = ST_OK;
                end
                FUNC_UP:
                begin
                    if (summary.hit)
                    begin
                        status_next = ST_OK;
                        wake_next   = 1'b1;
                    end
                end
                FUNC_DOWN:
                begin
                    // zero count: caller must retry later
                    if (summary.hit)
                        status_next = summary.zero ? ST_WAIT : ST_OK;
                end
                default:
                begin
                    status_next = ST_FAIL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.func       <= func_t'(req.func);
            req_reg.sem_name   <= req.sem_name;
            req_reg.init_value <= req.init_value;
        end
        status_reg <= status_next;
        handle_reg <= handle_next;
        wake_reg   <= wake_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.handle       = handle_reg;
    assign rsp.wake_waiters = wake_reg;

    // a resolved request always shows up as a result beat
    a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp.valid)
        else $error("resolved request produced no result beat");

    // a held request is never dropped before it is resolved
    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !fire |=> busy_reg)
        else $error("held request lost");

    // a successful open always reports a real entry handle
    a_open_handle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req_reg.func == FUNC_OPEN && ctl.open_ok
        |=> rsp.status == ST_OK && rsp.handle != '0)
        else $error("open succeeded without a handle");

    // must-wait answers carry no handle and wake nobody
    a_wait_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_WAIT |-> !rsp.wake_waiters && rsp.handle == '0)
        else $error("must-wait result carries stray fields");
endmodule

FILE: design/nst_cell.sv
module nst_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  nst_pkg::req_t                req,
    input  nst_pkg::cell_ctl_t           ctl,
    input  logic [nst_pkg::HANDLE_W-1:0] slot,
    input  nst_pkg::cell_link_t          link_in,
    output nst_pkg::cell_link_t          link_out
);
    import nst_pkg::*;

    logic                       valid_reg;
    logic                       valid_next;
    logic [NAME_W-1:0]          name_reg;
    logic [NAME_W-1:0]          name_next;
    logic [COUNT_W-1:0]         count_reg;
    logic [COUNT_W-1:0]         count_next;
    logic                       my_hit;
    logic                       my_first_free;
    logic                       count_zero;

    assign my_hit        = valid_reg && (name_reg == NAME_W'(req.sem_name));
    assign my_first_free = !valid_reg && !link_in.free_seen;
    assign count_zero    = (count_reg == '0);

    // fold this entry into the running summary
    always_comb
    begin
        link_out.free_seen = link_in.free_seen | !valid_reg;
        link_out.hit       = link_in.hit | my_hit;
        link_out.zero      = link_in.zero | (my_hit & count_zero);
        link_out.handle    = link_in.handle | (my_first_free ? slot : '0);
    end

    always_comb
    begin
        valid_next = valid_reg;
        name_next  = name_reg;
        count_next = count_reg;
        if (ctl.fire)
        begin
            case (req.func)
                FUNC_OPEN:
                begin
                    if (ctl.open_ok && my_first_free)
                    begin
                        valid_next = 1'b1;
                        name_next  = NAME_W'(req.sem_name);
                        count_next = COUNT_W'(req.init_value);
                    end
                end
                FUNC_CLOSE:
                begin
                    if (my_hit)
                        valid_next = 1'b0;
                end
                FUNC_UP:
                begin
                    if (my_hit && (count_zero || count_reg[COUNT_W-1]))
                        count_next = count_reg + COUNT_W'(1);
                end
                FUNC_DOWN:
                begin
                    if (my_hit && !count_zero && !count_reg[COUNT_W-1])
                        count_next = count_reg - COUNT_W'(1);
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        name_reg  <= name_next;
        count_reg <= count_next;
    end
endmodule

FILE: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nst_pkg::*;

    // cycles with no beat on either channel before the run is called hung
    localparam int QUIET_LIMIT   = 5000;
    // length of the receiver hold-off that backs the block up
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 90;
    localparam int POOL_SIZE     = 24;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed
    {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
        logic                wake;
    } reply_t;

    // what the sender put on the wire: a typed-in reply or none
    typedef struct packed
    {
        logic   typed;
        reply_t reply;
    } offer_t;

    typedef struct
    {
        func_t               func;
        logic [NAME_W-1:0]   name;
        logic [COUNT_W-1:0]  init;
        int                  reps;
        logic                typed;
        status_t             st;
        logic [HANDLE_W-1:0] hd;
        logic                wk;
    } step_row_t;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic clk;
    logic rst_n;

    nst_req_if req_ch ();
    nst_rsp_if rsp_ch ();

    named_semaphore_table uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the semaphore table
    logic               sem_in_use [TABLE_ENTRIES];
    logic [NAME_W-1:0]  sem_names  [TABLE_ENTRIES];
    logic [COUNT_W-1:0] sem_counts [TABLE_ENTRIES];

    offer_t offered_q[$];
    reply_t pending_replies[$];

    int fault_count     = 0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_left       = 0;
    bit pressure_armed  = 1'b0;
    bit pressure_done   = 1'b0;

    // directed walk: reset behavior, every function, count edges, full table
    step_row_t directed_steps [DIRECTED_ROWS] = '{
        // nothing open yet: every lookup misses
        '{FUNC_UP,    32'd5,         32'd0,         1,  1'b1, ST_FAIL, 7'd0, 1'b0},
        '{FUNC_DOWN,  32'd5,         32'd0,         1,  1'b1, ST_FAIL, 7'd0, 1'b0},
        '{FUNC_CLOSE, 32'd5,         32'd0,         1,  1'b1, ST_FAIL, 7'd0, 1'b0},
        // extreme names and counts claim the lowest entries in order
        '{FUNC_OPEN,  32'h8000_0000, 32'h7FFF_FFFF, 1,  1'b1, ST_OK,   7'd1, 1'b0},
        // name already in use
        '{FUNC_OPEN,  32'h8000_0000, 32'h0000_0000, 1,  1'b1, ST_FAIL, 7'd0, 1'b0},
        '{FUNC_OPEN,  32'h7FFF_FFFF, 32'h8000_0000, 1,  1'b1, ST_OK,   7'd2, 1'b0},
        '{FUNC_OPEN,  32'h0000_0000, 32'h0000_0000, 1,  1'b1, ST_OK,   7'd3, 1'b0},
        // zero count: must wait, then up from zero, then up saturates at one
        '{FUNC_DOWN,  32'h0000_0000, 32'd0,         1,  1'b1, ST_WAIT, 7'd0, 1'b0},
        '{FUNC_UP,    32'h0000_0000, 32'd0,         1,  1'b1, ST_OK,   7'd0, 1'b1},
        '{FUNC_UP,    32'h0000_0000, 32'd0,         1,  1'b1, ST_OK,   7'd0, 1'b1},
        '{FUNC_DOWN,  32'h0000_0000, 32'd0,         1,  1'b0, ST_OK,   7'd0, 1'b0},
        // negative count: down leaves it alone, up moves it toward zero
        '{FUNC_DOWN,  32'h7FFF_FFFF, 32'd0,         1,  1'b0, ST_OK,   7'd0, 1'b0},
        '{FUNC_UP,    32'h7FFF_FFFF, 32'd0,         1,  1'b0, ST_OK,   7'd0, 1'b0},
        // largest positive count
        '{FUNC_DOWN,  32'h8000_0000, 32'd0,         1,  1'b0, ST_OK,   7'd0, 1'b0},
        '{FUNC_UP,    32'h8000_0000, 32'd0,         1,  1'b0, ST_OK,   7'd0, 1'b0},
        '{FUNC_CLOSE, 32'h0000_0000, 32'd0,         1,  1'b1, ST_OK,   7'd0, 1'b0},
        '{FUNC_CLOSE, 32'h0000_0000, 32'd0,         1,  1'b1, ST_FAIL, 7'd0, 1'b0},
        // freed entry in the middle is reused first
        '{FUNC_OPEN,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,  1'b1, ST_OK,   7'd3, 1'b0},
        // fill the rest of the table, names counting up from the base
        '{FUNC_OPEN,  32'h5A00_0000, 32'h0000_0002, 13, 1'b0, ST_OK,   7'd0, 1'b0},
        // table full
        '{FUNC_OPEN,  32'h0BAD_F00D, 32'd1,         1,  1'b1, ST_FAIL, 7'd0, 1'b0},
        '{FUNC_DOWN,  32'hFFFF_FFFF, 32'd0,         1,  1'b0, ST_OK,   7'd0, 1'b0},
        '{FUNC_CLOSE, 32'h8000_0000, 32'd0,         1,  1'b1, ST_OK,   7'd0, 1'b0},
        '{FUNC_OPEN,  32'h0000_0001, 32'd1,         1,  1'b1, ST_OK,   7'd1, 1'b0},
        '{FUNC_DOWN,  32'h0000_0001, 32'd0,         1,  1'b0, ST_OK,   7'd0, 1'b0}
    };

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    // one request against the shadow table; updates it and returns the reply
    function automatic reply_t resolve_semaphore_request(func_t f, logic [NAME_W-1:0] nm,
                                                         logic [COUNT_W-1:0] iv);
        reply_t             r;
        int                 hit;
        int                 slot;
        logic [COUNT_W-1:0] c;
        r.status = ST_FAIL;
        r.handle = '0;
        r.wake   = 1'b0;
        hit      = -1;
        slot     = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (sem_in_use[i] && sem_names[i] == nm && hit < 0)
                hit = i;
            if (!sem_in_use[i] && slot < 0)
                slot = i;
        end
        if (f == FUNC_OPEN)
        begin
            if (hit < 0 && slot >= 0)
            begin
                sem_in_use[slot] = 1'b1;
                sem_names[slot]  = nm;
                sem_counts[slot] = iv;
                r.status         = ST_OK;
                r.handle         = HANDLE_W'(slot + 1);
            end
        end
        else if (hit >= 0)
        begin
            c = sem_counts[hit];
            case (f)
                FUNC_CLOSE:
                begin
                    sem_in_use[hit] = 1'b0;
                    r.status        = ST_OK;
                end
                FUNC_UP:
                begin
                    // count only climbs while it is below one
                    if (c == '0 || c[COUNT_W-1])
                        sem_counts[hit] = c + 1'b1;
                    r.status = ST_OK;
                    r.wake   = 1'b1;
                end
                default:
                begin
                    if (c == '0)
                        r.status = ST_WAIT;
                    else
                    begin
                        // negative counts pass through untouched
                        if (!c[COUNT_W-1])
                            sem_counts[hit] = c - 1'b1;
                        r.status = ST_OK;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // offer one request beat and hold it until the block takes it
    task automatic issue_request(func_t f, logic [NAME_W-1:0] nm, logic [COUNT_W-1:0] iv,
                                 logic typed, reply_t rp);
        while (chance(sender_idle_pct))
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        offered_q.push_back('{typed, rp});
        req_ch.valid      <= 1'b1;
        req_ch.func       <= f;
        req_ch.sem_name   <= nm;
        req_ch.init_value <= iv;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0 || offered_q.size() != 0)
            @(posedge clk);
    endtask

    // close every open semaphore so the next phase starts from an empty table
    task automatic close_all_open();
        logic [NAME_W-1:0] open_names[$];
        wait_until_drained();
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (sem_in_use[i])
                open_names.push_back(sem_names[i]);
        foreach (open_names[k])
            issue_request(FUNC_CLOSE, open_names[k], $urandom, 1'b0, '0);
        wait_until_drained();
    endtask

    // predictor and scoreboard, sampled on the edge before the block updates
    always @(posedge clk)
    begin
        reply_t predicted;
        reply_t expected;
        offer_t offer;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predicted = resolve_semaphore_request(func_t'(req_ch.func), req_ch.sem_name,
                                                      req_ch.init_value);
                if (offered_q.size() == 0)
                begin
                    fault_count++;
                    $display("request beat taken that was never offered");
                    pending_replies.push_back(predicted);
                end
                else
                begin
                    offer = offered_q.pop_front();
                    // rows with a typed-in reply are checked against that reply
                    pending_replies.push_back(offer.typed ? offer.reply : predicted);
                end
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    fault_count++;
                    $display("reply beat with no request outstanding: status %0d handle %0d",
                             rsp_ch.status, rsp_ch.handle);
                end
                else
                begin
                    expected = pending_replies.pop_front();
                    if (rsp_ch.status !== expected.status || rsp_ch.handle !== expected.handle
                        || rsp_ch.wake_waiters !== expected.wake)
                    begin
                        fault_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch %0t: status %0d/%0d handle %0d/%0d wake %0d/%0d",
                                     $realtime, expected.status, rsp_ch.status,
                                     expected.handle, rsp_ch.handle,
                                     expected.wake, rsp_ch.wake_waiters);
                    end
                end
            end
        end
    end

    // reply side: random stalls plus one long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pressure_armed && !pressure_done)
            begin
                hold_left     = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= !chance(recv_stall_pct);
        end
    end

    // watchdog: too long with no beat anywhere means the block is stuck
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog expired with %0d replies outstanding",
                         pending_replies.size());
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        logic [NAME_W-1:0]  name_pool [POOL_SIZE];
        logic [COUNT_W-1:0] extremes  [5];
        logic [NAME_W-1:0]  nm;
        logic [COUNT_W-1:0] iv;
        func_t              f;
        idle_mode_t         mode;
        bit                 filling;
        int                 pick;
        reply_t             typed_reply;

        extremes = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                     32'h7FFF_FFFF, 32'h8000_0000};
        for (int i = 0; i < TABLE_ENTRIES; i++)
            sem_in_use[i] = 1'b0;

        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FUNC_OPEN;
        req_ch.sem_name   <= '0;
        req_ch.init_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, no idling
        foreach (directed_steps[r])
        begin
            typed_reply = '{directed_steps[r].st, directed_steps[r].hd, directed_steps[r].wk};
            for (int k = 0; k < directed_steps[r].reps; k++)
                issue_request(directed_steps[r].func, directed_steps[r].name + k,
                              directed_steps[r].init, directed_steps[r].typed, typed_reply);
        end

        // random phases, each with an idling pattern chosen by phase; the last one
        // carries the long receiver hold-off while the sender keeps offering
        for (int ph = 0; ph < 5; ph++)
        begin
            mode = (ph == 4) ? IDLE_NONE : idle_mode_t'(ph);
            case (mode)
                IDLE_SENDER:   begin sender_idle_pct = 78; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 78; end
                IDLE_BOTH:     begin sender_idle_pct = 6;  recv_stall_pct = 6;  end
                default:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            close_all_open();

            // small name pool so requests mostly land on open semaphores
            for (int i = 0; i < POOL_SIZE; i++)
                name_pool[i] = (i < 4) ? NAME_W'(i) : (i < 9) ? extremes[i-4] : $urandom;
            if (ph == 4)
                pressure_armed = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 40 == 0)
                    filling = (n % 80 == 0);
                pick = $urandom_range(99);
                if (filling)
                    f = (pick < 45) ? FUNC_OPEN : (pick < 55) ? FUNC_CLOSE :
                        (pick < 75) ? FUNC_UP : FUNC_DOWN;
                else
                    f = (pick < 10) ? FUNC_OPEN : (pick < 50) ? FUNC_CLOSE :
                        (pick < 70) ? FUNC_UP : FUNC_DOWN;

                // a few stray names that match nothing
                nm = chance(12) ? NAME_W'($urandom) : name_pool[$urandom_range(POOL_SIZE-1)];

                pick = $urandom_range(99);
                if (pick < 40)
                    iv = COUNT_W'($urandom_range(5)) - 32'd2;
                else if (pick < 60)
                    iv = extremes[$urandom_range(4)];
                else
                    iv = $urandom;

                issue_request(f, nm, iv, 1'b0, '0);
            end
        end

        // wind down: everything answered, then a short settle
        wait_until_drained();
        repeat (8) @(posedge clk);
        if (fault_count == 0 && pending_replies.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
